FILE: design/spmd_pkg.sv
// ----------------------------------------------------------------------------
// spmd_pkg: shared types and widths for the segment pair distance pipeline
// Holds the fixed field widths and the stage counts of the distance units.
// ----------------------------------------------------------------------------
package spmd_pkg;

   localparam int CoordWidth   = 16;  // input coordinate, signed
   localparam int DiffWidth    = 17;  // coordinate difference, signed
   localparam int ProdWidth    = 34;  // product of two differences, signed
   localparam int SqWidth      = 33;  // squared norm, unsigned
   localparam int CrossWidth   = 35;  // cross product, signed
   localparam int AbsWidth     = 34;  // magnitude of the cross product
   localparam int NumWidth     = 69;  // search target and running product
   localparam int LinWidth     = 51;  // running d * c term
   localparam int DistWidth    = 17;  // distance, unsigned integer
   localparam int SearchSteps  = 17;  // one result bit per stage
   localparam int FrontStages  = 5;   // diff, product, sum, test, square
   localparam int UnitStages   = FrontStages + SearchSteps;
   localparam int NumStages    = UnitStages + 3;  // input, unit, min pair, output

   typedef enum logic [2:0] {
      SEL_END   = 3'b001,  // nearest point is the segment end
      SEL_START = 3'b010,  // nearest point is the segment start
      SEL_CROSS = 3'b100   // perpendicular foot lies inside the segment
   } sel_type;

endpackage

FILE: design/spmd_point_seg.sv
// ----------------------------------------------------------------------------
// spmd_point_seg: pipelined distance from one point to one segment
// Five front stages form the squared norms and the target, then one stage per
// result bit finds the largest d with d*d*den <= target, using adds only.
// ----------------------------------------------------------------------------
module spmd_point_seg (
   input  logic                                        clock,
   input  logic [spmd_pkg::UnitStages-1:0]             en,
   input  logic signed [spmd_pkg::CoordWidth-1:0]      px,
   input  logic signed [spmd_pkg::CoordWidth-1:0]      py,
   input  logic signed [spmd_pkg::CoordWidth-1:0]      qx,
   input  logic signed [spmd_pkg::CoordWidth-1:0]      qy,
   input  logic signed [spmd_pkg::CoordWidth-1:0]      rx,
   input  logic signed [spmd_pkg::CoordWidth-1:0]      ry,
   output logic [spmd_pkg::DistWidth-1:0]              seg_dist
);

   // stage 1: differences
   logic signed [spmd_pkg::DiffWidth-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   // stage 2: products
   logic signed [spmd_pkg::ProdWidth-1:0] axx_ff, ayy_ff, bxx_ff, byy_ff, cxx_ff, cyy_ff;
   logic signed [spmd_pkg::ProdWidth-1:0] axby_ff, aybx_ff;
   // stage 3: norms and cross product
   logic [spmd_pkg::SqWidth-1:0]           a3_ff, b3_ff, c3_ff;
   logic signed [spmd_pkg::CrossWidth-1:0] cr_ff;
   // stage 4: end tests
   logic [spmd_pkg::SqWidth-1:0]           a4_ff, b4_ff, c4_ff;
   logic [spmd_pkg::AbsWidth-1:0]          abs4_ff;
   spmd_pkg::sel_type                      sel4_ff;
   logic [spmd_pkg::SqWidth:0]             a_plus_c, b_plus_c;
   spmd_pkg::sel_type                      sel_in;
   // search chain, entry 0 is loaded by stage 5
   logic [spmd_pkg::DistWidth-1:0] d_ff   [0:spmd_pkg::SearchSteps];
   logic [spmd_pkg::NumWidth-1:0]  p_ff   [0:spmd_pkg::SearchSteps];
   logic [spmd_pkg::LinWidth-1:0]  q_ff   [0:spmd_pkg::SearchSteps];
   logic [spmd_pkg::NumWidth-1:0]  n_ff   [0:spmd_pkg::SearchSteps];
   logic [spmd_pkg::SqWidth-1:0]   den_ff [0:spmd_pkg::SearchSteps];
   logic [spmd_pkg::NumWidth-1:0]  n_in;
   logic [spmd_pkg::SqWidth-1:0]   den_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ax_ff <= spmd_pkg::DiffWidth'(rx) - spmd_pkg::DiffWidth'(qx);
         ay_ff <= spmd_pkg::DiffWidth'(ry) - spmd_pkg::DiffWidth'(qy);
         bx_ff <= spmd_pkg::DiffWidth'(rx) - spmd_pkg::DiffWidth'(px);
         by_ff <= spmd_pkg::DiffWidth'(ry) - spmd_pkg::DiffWidth'(py);
         cx_ff <= spmd_pkg::DiffWidth'(qx) - spmd_pkg::DiffWidth'(px);
         cy_ff <= spmd_pkg::DiffWidth'(qy) - spmd_pkg::DiffWidth'(py);
      end
      if (en[1]) begin
         axx_ff  <= spmd_pkg::ProdWidth'(ax_ff) * spmd_pkg::ProdWidth'(ax_ff);
         ayy_ff  <= spmd_pkg::ProdWidth'(ay_ff) * spmd_pkg::ProdWidth'(ay_ff);
         bxx_ff  <= spmd_pkg::ProdWidth'(bx_ff) * spmd_pkg::ProdWidth'(bx_ff);
         byy_ff  <= spmd_pkg::ProdWidth'(by_ff) * spmd_pkg::ProdWidth'(by_ff);
         cxx_ff  <= spmd_pkg::ProdWidth'(cx_ff) * spmd_pkg::ProdWidth'(cx_ff);
         cyy_ff  <= spmd_pkg::ProdWidth'(cy_ff) * spmd_pkg::ProdWidth'(cy_ff);
         axby_ff <= spmd_pkg::ProdWidth'(ax_ff) * spmd_pkg::ProdWidth'(by_ff);
         aybx_ff <= spmd_pkg::ProdWidth'(ay_ff) * spmd_pkg::ProdWidth'(bx_ff);
      end
      if (en[2]) begin
         a3_ff <= axx_ff[spmd_pkg::SqWidth-1:0] + ayy_ff[spmd_pkg::SqWidth-1:0];
         b3_ff <= bxx_ff[spmd_pkg::SqWidth-1:0] + byy_ff[spmd_pkg::SqWidth-1:0];
         c3_ff <= cxx_ff[spmd_pkg::SqWidth-1:0] + cyy_ff[spmd_pkg::SqWidth-1:0];
         cr_ff <= spmd_pkg::CrossWidth'(axby_ff) - spmd_pkg::CrossWidth'(aybx_ff);
      end
      if (en[3]) begin
         a4_ff   <= a3_ff;
         b4_ff   <= b3_ff;
         c4_ff   <= c3_ff;
         sel4_ff <= sel_in;
         abs4_ff <= cr_ff[spmd_pkg::CrossWidth-1]
                    ? spmd_pkg::AbsWidth'(-cr_ff) : spmd_pkg::AbsWidth'(cr_ff);
      end
      if (en[4]) begin
         d_ff[0]   <= '0;
         p_ff[0]   <= '0;
         q_ff[0]   <= '0;
         n_ff[0]   <= n_in;
         den_ff[0] <= den_in;
      end
   end

   // Endpoint tests in priority order; a zero-length segment falls to the end.
   always_comb begin
      a_plus_c = {1'b0, a3_ff} + {1'b0, c3_ff};
      b_plus_c = {1'b0, b3_ff} + {1'b0, c3_ff};
      priority if ({1'b0, b3_ff} >= a_plus_c) begin
         sel_in = spmd_pkg::SEL_END;
      end else if ({1'b0, a3_ff} >= b_plus_c) begin
         sel_in = spmd_pkg::SEL_START;
      end else if (c3_ff == '0) begin
         sel_in = spmd_pkg::SEL_END;
      end else begin
         sel_in = spmd_pkg::SEL_CROSS;
      end
   end

   // Endpoint case searches sqrt(norm) with den = 1; the cross case searches
   // cr / sqrt(c) as the largest d with d*d*c <= cr*cr.
   always_comb begin
      unique case (sel4_ff)
         spmd_pkg::SEL_END: begin
            n_in   = spmd_pkg::NumWidth'(a4_ff);
            den_in = spmd_pkg::SqWidth'(1);
         end
         spmd_pkg::SEL_START: begin
            n_in   = spmd_pkg::NumWidth'(b4_ff);
            den_in = spmd_pkg::SqWidth'(1);
         end
         default: begin
            n_in   = spmd_pkg::NumWidth'(abs4_ff) * spmd_pkg::NumWidth'(abs4_ff);
            den_in = c4_ff;
         end
      endcase
   end

   for (genvar g = 0; g < spmd_pkg::SearchSteps; g++) begin : g_step
      localparam int K = spmd_pkg::SearchSteps - 1 - g;
      logic [spmd_pkg::NumWidth-1:0] cand;
      logic                          take;

      // (d + 2^K)^2 * den = P + 2^(K+1) * Q + 2^(2K) * den
      assign cand = p_ff[g]
                  + (spmd_pkg::NumWidth'(q_ff[g]) << (K + 1))
                  + (spmd_pkg::NumWidth'(den_ff[g]) << (2 * K));
      assign take = (cand <= n_ff[g]);

      always_ff @(posedge clock) begin
         if (en[spmd_pkg::FrontStages + g]) begin
            d_ff[g+1]   <= take ? (d_ff[g] | spmd_pkg::DistWidth'(1 << K)) : d_ff[g];
            p_ff[g+1]   <= take ? cand : p_ff[g];
            q_ff[g+1]   <= take ? (q_ff[g] + (spmd_pkg::LinWidth'(den_ff[g]) << K))
                                : q_ff[g];
            n_ff[g+1]   <= n_ff[g];
            den_ff[g+1] <= den_ff[g];
         end
      end
   end

   assign seg_dist = d_ff[spmd_pkg::SearchSteps];

endmodule

FILE: design/segment_pair_min_distance.sv
// ----------------------------------------------------------------------------
// segment_pair_min_distance: minimum endpoint-to-segment distance of two
// 2-D segments
// Four point-to-segment units run side by side; a two-level minimum picks
// the smallest truncated distance.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    eight signed 16-bit coordinates
//   rsp      out        rsp_valid/stall    rsp_min_distance, 17 bits unsigned
//
// One transaction enters per cycle while req_stall is low; 25 register stages
// (input register, 22 unit stages, min pair, output register) lie between
// acceptance and rsp_valid. Most of that depth is the 17-stage bit search in
// each distance unit.
// Every stage carries a valid bit; a stage loads when it is empty or the next
// stage moves, so bubbles collapse under a stalled result.
// Synchronous reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module segment_pair_min_distance (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [spmd_pkg::CoordWidth-1:0]  req_first_start_x,
   input  logic signed [spmd_pkg::CoordWidth-1:0]  req_first_start_y,
   input  logic signed [spmd_pkg::CoordWidth-1:0]  req_first_end_x,
   input  logic signed [spmd_pkg::CoordWidth-1:0]  req_first_end_y,
   input  logic signed [spmd_pkg::CoordWidth-1:0]  req_second_start_x,
   input  logic signed [spmd_pkg::CoordWidth-1:0]  req_second_start_y,
   input  logic signed [spmd_pkg::CoordWidth-1:0]  req_second_end_x,
   input  logic signed [spmd_pkg::CoordWidth-1:0]  req_second_end_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [spmd_pkg::DistWidth-1:0]          rsp_min_distance
);

   localparam int Last = spmd_pkg::NumStages - 1;

   logic [spmd_pkg::NumStages-1:0] valid_ff;
   logic [spmd_pkg::NumStages-1:0] en;    // stage loads this cycle

   // input register
   logic signed [spmd_pkg::CoordWidth-1:0] p0x_ff, p0y_ff, p1x_ff, p1y_ff;
   logic signed [spmd_pkg::CoordWidth-1:0] q0x_ff, q0y_ff, q1x_ff, q1y_ff;

   logic [spmd_pkg::DistWidth-1:0] dist0, dist1, dist2, dist3;
   logic [spmd_pkg::DistWidth-1:0] min01_ff, min23_ff, out_ff;

   // A stage may load when it holds nothing or its content moves on.
   always_comb begin
      en[Last] = !valid_ff[Last] || !rsp_stall;
      for (int s = Last - 1; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   assign req_stall = !en[0];

   // Advance valid bits; a stage that loads takes its predecessor's bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < spmd_pkg::NumStages; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Capture the transaction payload.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         p0x_ff <= req_first_start_x;
         p0y_ff <= req_first_start_y;
         p1x_ff <= req_first_end_x;
         p1y_ff <= req_first_end_y;
         q0x_ff <= req_second_start_x;
         q0y_ff <= req_second_start_y;
         q1x_ff <= req_second_end_x;
         q1y_ff <= req_second_end_y;
      end
   end

   // Each endpoint of one segment against the other segment.
   spmd_point_seg u_first_vs_q0 (
      .clock    (clock),
      .en       (en[spmd_pkg::UnitStages:1]),
      .px       (p0x_ff), .py (p0y_ff), .qx (p1x_ff), .qy (p1y_ff),
      .rx       (q0x_ff), .ry (q0y_ff),
      .seg_dist (dist0)
   );

   spmd_point_seg u_first_vs_q1 (
      .clock    (clock),
      .en       (en[spmd_pkg::UnitStages:1]),
      .px       (p0x_ff), .py (p0y_ff), .qx (p1x_ff), .qy (p1y_ff),
      .rx       (q1x_ff), .ry (q1y_ff),
      .seg_dist (dist1)
   );

   spmd_point_seg u_second_vs_p0 (
      .clock    (clock),
      .en       (en[spmd_pkg::UnitStages:1]),
      .px       (q0x_ff), .py (q0y_ff), .qx (q1x_ff), .qy (q1y_ff),
      .rx       (p0x_ff), .ry (p0y_ff),
      .seg_dist (dist2)
   );

   spmd_point_seg u_second_vs_p1 (
      .clock    (clock),
      .en       (en[spmd_pkg::UnitStages:1]),
      .px       (q0x_ff), .py (q0y_ff), .qx (q1x_ff), .qy (q1y_ff),
      .rx       (p1x_ff), .ry (p1y_ff),
      .seg_dist (dist3)
   );

   // Reduce the four distances in two registered levels.
   always_ff @(posedge clock) begin
      if (en[Last-1]) begin
         min01_ff <= (dist1 < dist0) ? dist1 : dist0;
         min23_ff <= (dist3 < dist2) ? dist3 : dist2;
      end
      if (en[Last]) begin
         out_ff <= (min23_ff < min01_ff) ? min23_ff : min01_ff;
      end
   end

   assign rsp_valid        = valid_ff[Last];
   assign rsp_min_distance = out_ff;

endmodule

FILE: tb/tb_segment_pair_min_distance.sv
// ----------------------------------------------------------------------------
// tb_segment_pair_min_distance: self-checking bench for the segment pair
// minimum distance pipeline
// A queue-fed driver offers segment pairs under several idle/stall phases; a
// monitor checks each result against an exact integer prediction.
// ----------------------------------------------------------------------------
module tb_segment_pair_min_distance;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency    = spmd_pkg::NumStages;
   localparam int CycleLimit = 400000;

   typedef logic signed [spmd_pkg::CoordWidth-1:0] coord_type;
   typedef struct packed {
      coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   } seg_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   seg_pair_type cur = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [spmd_pkg::DistWidth-1:0] rsp_min_distance;

   seg_pair_type pending_pairs[$];
   logic [spmd_pkg::DistWidth-1:0] expected_dist[$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_rsp = 1'b0;
   int hold_cycles = 0;

   always #5 clock = ~clock;

   segment_pair_min_distance uut (
      .clock, .reset, .req_valid, .req_stall,
      .req_first_start_x(cur.ax0), .req_first_start_y(cur.ay0),
      .req_first_end_x(cur.ax1), .req_first_end_y(cur.ay1),
      .req_second_start_x(cur.bx0), .req_second_start_y(cur.by0),
      .req_second_end_x(cur.bx1), .req_second_end_y(cur.by1),
      .rsp_valid, .rsp_stall, .rsp_min_distance
   );

   // Integer square root, truncated.
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Truncated integer distance of point r to segment p-q.
   function automatic logic [spmd_pkg::DistWidth-1:0] point_to_segment(
         longint px, longint py, longint qx, longint qy, longint rx, longint ry);
      longint ax, ay, bx, by, cx, cy, cr;
      logic [127:0] a, b, c, cr2, t;
      logic [spmd_pkg::DistWidth-1:0] d;
      ax = rx - qx; ay = ry - qy;
      bx = rx - px; by = ry - py;
      cx = qx - px; cy = qy - py;
      a = ax * ax + ay * ay;
      b = bx * bx + by * by;
      c = cx * cx + cy * cy;
      if (b >= a + c) return spmd_pkg::DistWidth'(int_sqrt(a[63:0]));
      if (a >= b + c) return spmd_pkg::DistWidth'(int_sqrt(b[63:0]));
      if (c == 0) return spmd_pkg::DistWidth'(int_sqrt(a[63:0]));
      cr = ax * by - ay * bx;
      if (cr < 0) cr = -cr;
      cr2 = 128'(cr) * 128'(cr);
      d = '0;
      // Bit search: largest d with d*d*c <= cr*cr.
      for (int k = spmd_pkg::DistWidth - 1; k >= 0; k--) begin
         t = 128'(d | (17'd1 << k));
         if (t * t * c <= cr2) d = t[spmd_pkg::DistWidth-1:0];
      end
      return d;
   endfunction

   function automatic logic [spmd_pkg::DistWidth-1:0] predict_min_distance(
         seg_pair_type s);
      logic [spmd_pkg::DistWidth-1:0] m, d;
      m = point_to_segment(s.ax0, s.ay0, s.ax1, s.ay1, s.bx0, s.by0);
      d = point_to_segment(s.ax0, s.ay0, s.ax1, s.ay1, s.bx1, s.by1);
      if (d < m) m = d;
      d = point_to_segment(s.bx0, s.by0, s.bx1, s.by1, s.ax0, s.ay0);
      if (d < m) m = d;
      d = point_to_segment(s.bx0, s.by0, s.bx1, s.by1, s.ax1, s.ay1);
      if (d < m) m = d;
      return m;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic coord_type rand_coord(int spread);
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return coord_type'($urandom);
         default: return coord_type'($signed($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   // Offset point near a base, to build close pairs.
   function automatic coord_type near(coord_type base, int spread);
      return coord_type'(int'(base) + $signed($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic seg_pair_type rand_pair();
      seg_pair_type s;
      int spread;
      spread = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 2000);
      s.ax0 = rand_coord(spread); s.ay0 = rand_coord(spread);
      s.ax1 = rand_coord(spread); s.ay1 = rand_coord(spread);
      s.bx0 = rand_coord(spread); s.by0 = rand_coord(spread);
      s.bx1 = rand_coord(spread); s.by1 = rand_coord(spread);
      case ($urandom_range(0, 7))
         0: begin s.ax1 = s.ax0; s.ay1 = s.ay0; end   // degenerate first
         1: begin s.bx1 = s.bx0; s.by1 = s.by0; end   // degenerate second
         2: begin s.bx0 = near(s.ax0, 40); s.by0 = near(s.ay0, 40); end
         3: begin s.bx0 = s.ax1; s.by0 = s.ay1; end   // shared endpoint
         default: ;
      endcase
      return s;
   endfunction

   // Driver: advance on acceptance, hold payload while stalled.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur <= pending_pairs[0];
               expected_dist.push_back(predict_min_distance(pending_pairs[0]));
               void'(pending_pairs.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dist.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d", rsp_min_distance));
            end else begin
               if (rsp_min_distance !== expected_dist[0])
                  report_mismatch($sformatf("min_distance got %0d expected %0d",
                                            rsp_min_distance, expected_dist[0]));
               void'(expected_dist.pop_front());
            end
         end
         if (hold_rsp)
            rsp_stall <= 1'b1;
         else
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Long receiver hold-off, counted in its own process.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_rsp <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         hold_rsp <= 1'b0;
      end
   end

   task automatic drain();
      while (pending_pairs.size() > 0 || expected_dist.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   task automatic run_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
      drain();
   endtask

   // Watchdog.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      seg_pair_type s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, degenerate, crossing, collinear, projection cases.
      pending_pairs.push_back('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                                16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
      pending_pairs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      pending_pairs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
                                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000});
      pending_pairs.push_back('0);
      pending_pairs.push_back('{0, 0, 0, 0, 16'sd16, 16'sd0, 16'sd16, 16'sd0});
      pending_pairs.push_back('{-16, 0, 16, 0, 0, -16, 0, 16});
      pending_pairs.push_back('{0, 0, 160, 0, 80, 33, 90, 77});
      pending_pairs.push_back('{0, 0, 160, 0, -50, 20, -90, 5});
      pending_pairs.push_back('{0, 0, 160, 0, 300, 20, 250, 9});
      pending_pairs.push_back('{0, 0, 100, 0, 200, 0, 300, 0});
      pending_pairs.push_back('{0, 0, 100, 0, 100, 0, 300, 7});
      pending_pairs.push_back('{3, 7, 3, 7, -5, 2, 11, 2});
      pending_pairs.push_back('{-1, -1, -1, -1, -1, -1, -1, -1});
      pending_pairs.push_back('{16'sh7fff, 0, 16'sh8000, 0, 0, 16'sh7fff, 0, 1});
      pending_pairs.push_back('{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                                16'sh0f0f, 16'shf0f0, 16'shf0f0, 16'sh0f0f});
      drain();

      run_phase(120, 0, 0);
      run_phase(100, 51, 0);
      run_phase(100, 0, 51);
      run_phase(100, 18, 18);

      // Long hold-off so the pipeline fills and stalls its input.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 80;
      for (int i = 0; i < 80; i++) pending_pairs.push_back(rand_pair());
      drain();

      // Sender pause until everything has come out, then a final burst.
      s = rand_pair();
      pending_pairs.push_back(s);
      drain();
      run_phase(50, 18, 18);

      repeat (Latency + 10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
